[rtl/rma_pkg.sv]
// ----------------------------------------------------------------------------
// rma_pkg
// Shared types and constants of the register map allocator.
// ----------------------------------------------------------------------------
package rma_pkg;

  // Virtual register space, set by the 10-bit virtual register field
  localparam int unsigned VIRT_AW   = 10;
  localparam int unsigned VIRT_REGS = 1 << VIRT_AW;

  // Width of the physical register number on the result port
  localparam int unsigned PHYS_OW = 3;

  // Operation codes; the remaining code is ignored
  typedef enum logic [1:0] {
    OP_MAP        = 2'd0,
    OP_RELEASE    = 2'd1,
    OP_FUNC_START = 2'd2
  } op_e;

endpackage

[rtl/register_map_allocator.sv]
// ----------------------------------------------------------------------------
// register_map_allocator
// Maps virtual register numbers onto a small pool of physical registers.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+------------------------
//   input    | in        | in_valid_i / in_ready_o    | op_i, virt_reg_i
//   result   | out       | out_valid_o / out_ready_i  | phys_reg_o, was_mapped_o,
//            |           |                            | out_of_regs_o
//
// One transaction per cycle is sustained while the result channel does not
// stall; a result passes from its input transaction through the map table
// read, then lookup/allocate into the result register. The table read is
// registered, so a write from the previous transaction is forwarded to the
// next one when both use the same virtual register. After reset a clearing
// pass writes every map table entry invalid, one entry per cycle; in_ready_o
// is low during that pass. A stalled result holds the lookup stage, which in
// turn holds off new input.
// ----------------------------------------------------------------------------
module register_map_allocator
  import rma_pkg::*;
#(
  parameter int unsigned PHYS_REGS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [VIRT_AW-1:0]  virt_reg_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PHYS_OW-1:0]  phys_reg_o,
  output logic                was_mapped_o,
  output logic                out_of_regs_o
);

  localparam int unsigned PW = (PHYS_REGS > 1) ? $clog2(PHYS_REGS) : 1;
  localparam int unsigned EW = PW + 1;  // valid bit plus physical number

  // Lowest clear bit of the in-use mask
  function automatic logic [PW-1:0] lowest_free(input logic [PHYS_REGS-1:0] used);
    logic [PW-1:0] idx;
    idx = '0;
    for (int i = PHYS_REGS - 1; i >= 0; i--) begin
      if (!used[i]) idx = PW'(i);
    end
    return idx;
  endfunction

  // Map table storage
  logic [EW-1:0]         map_mem [VIRT_REGS];
  logic [EW-1:0]         rdata_q;
  logic                  mem_we;
  logic [VIRT_AW-1:0]    mem_waddr;
  logic [EW-1:0]         mem_wdata;

  // Clearing pass
  logic                  clearing_q;
  logic [VIRT_AW-1:0]    clr_cnt_q;

  // Lookup stage
  logic                  s1_valid_q;
  logic [1:0]            s1_op_q;
  logic [VIRT_AW-1:0]    s1_virt_q;
  logic                  fwd_hit_q;
  logic [EW-1:0]         fwd_entry_q;
  logic [PHYS_REGS-1:0]  in_use_q, in_use_d;

  // Result register
  logic                  out_valid_q;
  logic [PHYS_OW-1:0]    phys_q, phys_d;
  logic                  mapped_q, mapped_d;
  logic                  oor_q, oor_d;

  logic                  in_acc;
  logic                  s1_adv;
  logic [EW-1:0]         entry;
  logic [PW-1:0]         free_idx;
  logic                  any_free;
  logic                  alloc_we;
  logic [EW-1:0]         alloc_entry;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // Table entry seen by the lookup stage, with write forwarding
  assign entry       = fwd_hit_q ? fwd_entry_q : rdata_q;
  assign free_idx    = lowest_free(in_use_q);
  assign any_free    = ~&in_use_q;
  assign alloc_entry = {1'b1, free_idx};

  // Lookup / allocate / release
  always_comb begin
    in_use_d = in_use_q;
    phys_d   = '0;
    mapped_d = 1'b0;
    oor_d    = 1'b0;
    alloc_we = 1'b0;
    case (s1_op_q)
      OP_MAP, OP_RELEASE: begin
        if (entry[PW]) begin
          phys_d   = PHYS_OW'(entry[PW-1:0]);
          mapped_d = 1'b1;
          if (s1_op_q == OP_RELEASE) begin
            in_use_d = in_use_q & ~(PHYS_REGS'(1) << entry[PW-1:0]);
          end
        end else if (any_free) begin
          phys_d   = PHYS_OW'(free_idx);
          alloc_we = 1'b1;
          if (s1_op_q == OP_MAP) begin
            in_use_d = in_use_q | (PHYS_REGS'(1) << free_idx);
          end
        end else begin
          oor_d = 1'b1;
        end
      end
      OP_FUNC_START: begin
        in_use_d = '0;
      end
      default: ;
    endcase
  end

  // Memory write port: clearing pass or allocation
  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && alloc_we;
      mem_waddr = s1_virt_q;
      mem_wdata = alloc_entry;
    end
  end

  // Map table memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_q <= map_mem[virt_reg_i];
    end
  end

  // Clearing pass control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == VIRT_AW'(VIRT_REGS - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + VIRT_AW'(1);
      end
    end
  end

  // Lookup stage control and in-use mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_use_q    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        in_use_q    <= in_use_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Lookup stage payload and forwarding of the allocation write
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= op_i;
      s1_virt_q   <= virt_reg_i;
      fwd_hit_q   <= s1_adv && alloc_we && (s1_virt_q == virt_reg_i);
      fwd_entry_q <= alloc_entry;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      phys_q   <= phys_d;
      mapped_q <= mapped_d;
      oor_q    <= oor_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phys_reg_o    = phys_q;
  assign was_mapped_o  = mapped_q;
  assign out_of_regs_o = oor_q;

endmodule

[rtl/rma_checker.sv]
// ----------------------------------------------------------------------------
// rma_checker
// Port-level checks of the register map allocator.
// ----------------------------------------------------------------------------
module rma_checker
  import rma_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          op_i,
  input logic [VIRT_AW-1:0]  virt_reg_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [PHYS_OW-1:0]  phys_reg_o,
  input logic                was_mapped_o,
  input logic                out_of_regs_o
);

  // A stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phys_reg_o)
      && $stable(was_mapped_o) && $stable(out_of_regs_o))
    else $error("result transaction changed while stalled");

  // An exhausted pool reports no register and no existing mapping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_regs_o |-> phys_reg_o == '0 && !was_mapped_o)
    else $error("out-of-registers result carries a mapping");

  // The table is being cleared right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input accepted during clearing pass");

  // A new result follows an accepted input transaction, through the table read and lookup stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching input transaction");

endmodule

bind register_map_allocator rma_checker u_rma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .op_i          (op_i),
  .virt_reg_i    (virt_reg_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .phys_reg_o    (phys_reg_o),
  .was_mapped_o  (was_mapped_o),
  .out_of_regs_o (out_of_regs_o)
);

[tb/register_map_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_map_allocator_tb
// Self-checking bench for the register map allocator. A directed sequence hits
// the field extremes, every op, pool exhaustion, stale mappings and releases;
// random function bodies over small virtual register windows follow. A
// scoreboard predicts each result from its own copy of the map table and
// in-use bits, and checks the results in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module register_map_allocator_tb;
  import rma_pkg::*;

  localparam int unsigned NUM_PHYS     = 7;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS = 1650;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [PHYS_OW-1:0] phys;
    logic               hit;
    logic               no_free;
  } alloc_res_t;

  // Scoreboard: shadow map table, in-use bits and pending allocation results
  class alloc_scoreboard;
    bit                 map_valid [VIRT_REGS];
    logic [PHYS_OW-1:0] map_phys  [VIRT_REGS];
    logic [NUM_PHYS-1:0] in_use;
    alloc_res_t         pending_alloc[$];
    int                 n_errors;

    function new();
      in_use   = '0;
      n_errors = 0;
      foreach (map_valid[i]) begin
        map_valid[i] = 1'b0;
        map_phys[i]  = '0;
      end
    endfunction

    // Predict the result of one accepted request transaction
    function void note_request(logic [1:0] op, logic [VIRT_AW-1:0] vr);
      alloc_res_t res;
      bit         found;
      res   = '0;
      found = 1'b0;
      case (op)
        OP_FUNC_START: in_use = '0;
        OP_MAP, OP_RELEASE: begin
          if (map_valid[vr]) begin
            // recorded mapping wins, even if its in-use bit is clear
            res.phys = map_phys[vr];
            res.hit  = 1'b1;
            found    = 1'b1;
          end else begin
            for (int i = 0; i < NUM_PHYS; i++) begin
              if (!found && !in_use[i]) begin
                found         = 1'b1;
                map_valid[vr] = 1'b1;
                map_phys[vr]  = i[PHYS_OW-1:0];
                in_use[i]     = 1'b1;
                res.phys      = i[PHYS_OW-1:0];
              end
            end
            if (!found) res.no_free = 1'b1;
          end
          if (found && op == OP_RELEASE) in_use[res.phys] = 1'b0;
        end
        default: ;
      endcase
      pending_alloc.push_back(res);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [PHYS_OW-1:0] phys, logic hit, logic no_free);
      alloc_res_t exp_res;
      if (pending_alloc.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual phys %0d mapped %0b oor %0b",
                 $time, phys, hit, no_free);
        n_errors++;
        return;
      end
      exp_res = pending_alloc.pop_front();
      if (phys !== exp_res.phys) begin
        $display("%0t: phys_reg expected %0d actual %0d", $time, exp_res.phys, phys);
        n_errors++;
      end
      if (hit !== exp_res.hit) begin
        $display("%0t: was_mapped expected %0b actual %0b", $time, exp_res.hit, hit);
        n_errors++;
      end
      if (no_free !== exp_res.no_free) begin
        $display("%0t: out_of_regs expected %0b actual %0b", $time, exp_res.no_free,
                 no_free);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic [VIRT_AW-1:0] virt_reg_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [PHYS_OW-1:0] phys_reg_o;
  logic               was_mapped_o;
  logic               out_of_regs_o;

  alloc_scoreboard    sb;
  bit                 no_idle;
  logic [VIRT_AW-1:0] last_vr;
  int                 cycle_cnt;

  register_map_allocator #(
    .PHYS_REGS(NUM_PHYS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .virt_reg_i   (virt_reg_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phys_reg_o   (phys_reg_o),
    .was_mapped_o (was_mapped_o),
    .out_of_regs_o(out_of_regs_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("register_map_allocator_tb: errors");
      $finish;
    end
  end

  // Idle cycles before the next transaction; none during burst stretches
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Drive one request transaction and record it once accepted
  task automatic send_req(input logic [1:0] op, input logic [VIRT_AW-1:0] vr);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    virt_reg_i <= vr;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(op, vr);
    last_vr = vr;
  endtask

  // Pick a virtual register: repeat, window around base, or anywhere
  function automatic logic [VIRT_AW-1:0] pick_vreg(logic [VIRT_AW-1:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return last_vr;
    if (r < 65) return base + VIRT_AW'($urandom_range(0, 15));
    return VIRT_AW'($urandom_range(0, VIRT_REGS - 1));
  endfunction

  // Result side: random back-pressure, check every accepted transaction
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(phys_reg_o, was_mapped_o, out_of_regs_o);
    end
  end

  // Stimulus
  initial begin
    int                 counted;
    int                 body_len;
    int                 r;
    logic [VIRT_AW-1:0] base;
    logic [1:0]         op;

    sb         = new();
    no_idle    = 1'b0;
    last_vr    = '0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = OP_MAP;
    virt_reg_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every op, stale hit, exhaustion, release on exhaustion
    send_req(OP_MAP, 10'd0);
    send_req(OP_MAP, 10'd1023);
    send_req(OP_MAP, 10'd0);
    send_req(OP_RELEASE, 10'd1023);
    send_req(OP_MAP, 10'd5);
    send_req(OP_UNUSED, 10'd1023);
    send_req(OP_FUNC_START, 10'h2AA);
    send_req(OP_MAP, 10'd1023);
    for (int i = 0; i < NUM_PHYS; i++) send_req(OP_MAP, VIRT_AW'(100 + i));
    send_req(OP_MAP, 10'd107);
    send_req(OP_RELEASE, 10'd108);
    send_req(OP_RELEASE, 10'h155);
    send_req(OP_FUNC_START, 10'd0);
    send_req(OP_RELEASE, 10'd200);
    send_req(OP_MAP, 10'd201);
    send_req(OP_MAP, 10'd201);

    // Random function bodies over small windows, with some noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      base     = VIRT_AW'($urandom_range(0, VIRT_REGS - 1));
      body_len = $urandom_range(2, 20);
      send_req(OP_FUNC_START, pick_vreg(base));
      counted++;
      for (int k = 0; k < body_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6)       op = OP_UNUSED;
        else if (r < 10) op = OP_FUNC_START;
        else if (r < 40) op = OP_RELEASE;
        else             op = OP_MAP;
        send_req(op, pick_vreg(base));
        counted++;
      end
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    // Drain
    while (sb.pending_alloc.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("register_map_allocator_tb: clean");
    end else begin
      $display("register_map_allocator_tb: errors");
    end
    $finish;
  end

endmodule
